/* rtl/gbts_pkg.sv */
// ----------------------------------------------------------------------------
// gbts_pkg: shared types and constants of the gap buffer text store
// Field widths, opcodes, status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 4096;

  localparam int unsigned OPC_W = 3;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned OFS_W = 14;
  localparam int unsigned POS_W = 13;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_MOVE_REL = 3'd1,
    OP_MOVE_ABS = 3'd2,
    OP_DEL_FWD  = 3'd3,
    OP_DEL_BWD  = 3'd4,
    OP_READ     = 3'd5,
    OP_CLEAR    = 3'd6
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_MOVE,
    S_COPY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CH_W-1:0]  rd_char;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] text_length;
    logic [POS_W-1:0] cursor;
  } res_t;

endpackage

/* rtl/gbts_in_if.sv */
// ----------------------------------------------------------------------------
// gbts_in_if: request channel of the gap buffer text store
// Valid/ready handshake carrying opcode, character, offset and position.
// ----------------------------------------------------------------------------
interface gbts_in_if;
  import gbts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic [CH_W-1:0]         ch;
  logic signed [OFS_W-1:0] offset;
  logic [POS_W-1:0]        position;

  modport source (output valid, output opcode, output ch, output offset,
                  output position, input ready);
  modport sink   (input valid, input opcode, input ch, input offset,
                  input position, output ready);
endinterface

/* rtl/gbts_out_if.sv */
// ----------------------------------------------------------------------------
// gbts_out_if: result channel of the gap buffer text store
// Valid/ready handshake carrying read character, status, length and cursor.
// ----------------------------------------------------------------------------
interface gbts_out_if;
  import gbts_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  rd_char;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] text_length;
  logic [POS_W-1:0] cursor;

  modport source (output valid, output rd_char, output status,
                  output text_length, output cursor, input ready);
  modport sink   (input valid, input rd_char, input status,
                  input text_length, input cursor, output ready);
endinterface

/* rtl/gbts_ram.sv */
// ----------------------------------------------------------------------------
// gbts_ram: character store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int unsigned DEPTH = gbts_pkg::CAPACITY_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [gbts_pkg::CH_W-1:0] wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [gbts_pkg::CH_W-1:0] rdata_o
);
  import gbts_pkg::*;

  logic [CH_W-1:0] mem_q [DEPTH];
  logic [CH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gbts_ctrl.sv */
// ----------------------------------------------------------------------------
// gbts_ctrl: request sequencer and gap pointers
// Decodes one request, checks it, then steps the gap one character at a time.
// ----------------------------------------------------------------------------
module gbts_ctrl #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned PW = $clog2(CAPACITY + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gbts_in_if.sink                   in_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output gbts_pkg::res_t            res_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [gbts_pkg::CH_W-1:0] mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [gbts_pkg::CH_W-1:0] mem_rdata_i
);
  import gbts_pkg::*;

  localparam int unsigned CW = (PW > POS_W) ? PW : POS_W;
  localparam int unsigned SW = ((PW > OFS_W) ? PW : OFS_W) + 1;

  state_e state_q, state_d;

  logic [PW-1:0]           begin_q, begin_d;
  logic [PW-1:0]           finish_q, finish_d;
  logic [PW-1:0]           target_q, target_d;
  logic                    left_q, left_d;
  status_e                 status_q, status_d;
  logic [CH_W-1:0]         rd_q, rd_d;
  logic [OPC_W-1:0]        op_q, op_d;
  logic [CH_W-1:0]         ch_q, ch_d;
  logic signed [OFS_W-1:0] ofs_q, ofs_d;
  logic [POS_W-1:0]        pos_q, pos_d;

  logic [PW-1:0]        gap_w, len_w, begin_m1, finish_m1, rd_idx;
  logic [CW-1:0]        pos_c, len_c;
  logic signed [SW-1:0] tgt_s;
  status_e              exec_st;

  // Shared pointer arithmetic
  assign gap_w     = finish_q - begin_q;
  assign len_w     = PW'(CAPACITY) - gap_w;
  assign begin_m1  = begin_q - 1'b1;
  assign finish_m1 = finish_q - 1'b1;
  assign pos_c     = CW'(pos_q);
  assign len_c     = CW'(len_w);
  assign tgt_s     = $signed(SW'(begin_q)) + SW'(ofs_q);
  assign rd_idx    = (pos_c < CW'(begin_q)) ? pos_c[PW-1:0] : pos_c[PW-1:0] + gap_w;

  // Request check
  always_comb begin
    exec_st = ST_OK;
    case (op_q)
      OP_INSERT:   if (begin_q >= finish_q) exec_st = ST_FULL;
      OP_MOVE_REL: if (tgt_s[SW-1] || (tgt_s > $signed(SW'(len_w)))) exec_st = ST_RANGE;
      OP_MOVE_ABS: if (pos_c > len_c) exec_st = ST_RANGE;
      OP_DEL_FWD:  if (pos_c > CW'(PW'(CAPACITY) - finish_q)) exec_st = ST_RANGE;
      OP_DEL_BWD:  if (pos_c > CW'(begin_q)) exec_st = ST_RANGE;
      OP_READ:     if (pos_c >= len_c) exec_st = ST_RANGE;
      OP_CLEAR:    exec_st = ST_OK;
      default:     exec_st = ST_RANGE;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_EXEC;
      S_EXEC: begin
        if (exec_st != ST_OK) begin
          state_d = S_DONE;
        end else if (op_q == OP_READ) begin
          state_d = S_READ;
        end else if ((op_q == OP_MOVE_REL) || (op_q == OP_MOVE_ABS)) begin
          state_d = S_MOVE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: state_d = S_DONE;
      S_MOVE: state_d = (begin_q == target_q) ? S_DONE : S_COPY;
      S_COPY: state_d = S_MOVE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    mem_we_o    = 1'b0;
    mem_waddr_o = begin_q[AW-1:0];
    mem_wdata_o = ch_q;
    mem_raddr_o = rd_idx[AW-1:0];
    case (state_q)
      S_EXEC: mem_we_o = (op_q == OP_INSERT) && (exec_st == ST_OK);
      S_MOVE: mem_raddr_o = (begin_q > target_q) ? begin_m1[AW-1:0] : finish_q[AW-1:0];
      S_COPY: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        mem_waddr_o = left_q ? finish_m1[AW-1:0] : begin_q[AW-1:0];
      end
      default: mem_we_o = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    begin_d  = begin_q;
    finish_d = finish_q;
    target_d = target_q;
    left_d   = left_q;
    status_d = status_q;
    rd_d     = rd_q;
    op_d     = op_q;
    ch_d     = ch_q;
    ofs_d    = ofs_q;
    pos_d    = pos_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d  = in_i.opcode;
          ch_d  = in_i.ch;
          ofs_d = in_i.offset;
          pos_d = in_i.position;
        end
      end
      S_EXEC: begin
        status_d = exec_st;
        rd_d     = '0;
        if (exec_st == ST_OK) begin
          case (op_q)
            OP_INSERT:   begin_d  = begin_q + 1'b1;
            OP_MOVE_REL: target_d = tgt_s[PW-1:0];
            OP_MOVE_ABS: target_d = pos_c[PW-1:0];
            OP_DEL_FWD:  finish_d = finish_q + pos_c[PW-1:0];
            OP_DEL_BWD:  begin_d  = begin_q - pos_c[PW-1:0];
            OP_CLEAR: begin
              begin_d  = '0;
              finish_d = PW'(CAPACITY);
            end
            default: target_d = target_q;
          endcase
        end
      end
      S_READ: rd_d = mem_rdata_i;
      S_MOVE: left_d = (begin_q > target_q);
      S_COPY: begin
        if (left_q) begin
          begin_d  = begin_m1;
          finish_d = finish_m1;
        end else begin
          begin_d  = begin_q + 1'b1;
          finish_d = finish_q + 1'b1;
        end
      end
      default: rd_d = rd_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      begin_q  <= '0;
      finish_q <= PW'(CAPACITY);
    end else begin
      state_q  <= state_d;
      begin_q  <= begin_d;
      finish_q <= finish_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    left_q   <= left_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    op_q     <= op_d;
    ch_q     <= ch_d;
    ofs_q    <= ofs_d;
    pos_q    <= pos_d;
  end

  assign res_o.rd_char     = rd_q;
  assign res_o.status      = status_q;
  assign res_o.text_length = POS_W'(len_w);
  assign res_o.cursor      = POS_W'(begin_q);

endmodule

/* rtl/gap_buffer_text_store.sv */
// Sequence: a request is checked in S_EXEC; insert, delete, clear and rejected ones
//   then go to S_DONE, a read by way of S_READ, a cursor move by S_MOVE and S_COPY for each character moved.
// Throughput: one request at a time; the next is taken in the cycle after the result leaves
//   the sequencer. Each character copied across the gap costs a read and a write on the
//   single-port-pair character store.
// Reset: cursor and gap start at zero, text empty; store contents stay undefined.
// ----------------------------------------------------------------------------
// gap_buffer_text_store: fixed-capacity text gap buffer
// Insert, move, delete, read and clear requests on a character store with a gap
// at the cursor; one result per request through an output register.
// ----------------------------------------------------------------------------
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbts_in_if.sink   in_i,
  gbts_out_if.source out_o
);
  import gbts_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // Sequencer to output register
  logic            res_valid;
  logic            res_ready;
  res_t            res;

  // Sequencer to character store
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CH_W-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [CH_W-1:0] mem_rdata;

  // Output register
  logic            out_valid_q;
  res_t            out_q;

  gbts_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  gbts_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Take a finished result when the output register is empty or being drained,
  // so the sequencer never waits on a consumer that is about to take its result.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rd_char     = out_q.rd_char;
  assign out_o.status      = out_q.status;
  assign out_o.text_length = out_q.text_length;
  assign out_o.cursor      = out_q.cursor;

endmodule

/* rtl/gbts_chk.sv */
// ----------------------------------------------------------------------------
// gbts_chk: port-level checks of the gap buffer text store
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module gbts_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [gbts_pkg::CH_W-1:0]  rd_char_i,
  input logic [gbts_pkg::ST_W-1:0]  status_i,
  input logic [gbts_pkg::POS_W-1:0] text_length_i,
  input logic [gbts_pkg::POS_W-1:0] cursor_i
);
  import gbts_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(cursor_i) && $stable(text_length_i) && $stable(rd_char_i))
    else $error("result changed while stalled");

  // One request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // Status is one of the three codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK) || (status_i == ST_FULL) ||
    (status_i == ST_RANGE))
    else $error("undefined status code");

  // Cursor never lies beyond the text
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cursor_i <= text_length_i)
    else $error("cursor beyond text length");

  // A failed request reads nothing
  a_fail_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> rd_char_i == '0)
    else $error("character returned on failed request");

endmodule

bind gap_buffer_text_store gbts_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .rd_char_i     (out_o.rd_char),
  .status_i      (out_o.status),
  .text_length_i (out_o.text_length),
  .cursor_i      (out_o.cursor)
);

/* test/tb_gap_buffer_text_store.sv */
// ----------------------------------------------------------------------------
// tb_gap_buffer_text_store: self-checking bench for the gap buffer text store
// Drives edit requests through the request channel, with random idling on both
// sides. Checks every result against an in-bench gap buffer: a short directed
// run, a long fill with long cursor moves, then random edit traffic.
// ----------------------------------------------------------------------------
module tb_gap_buffer_text_store;
  import gbts_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int unsigned RANDOM_EDITS = 1075;
  localparam int unsigned FILL_CHARS   = 639;
  localparam int unsigned HALF_TEXT    = (FILL_CHARS + 1) / 2;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned MAX_PRINTED  = 100;
  // Opcode seven carries no meaning; the block must refuse it.
  localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [OPC_W-1:0]        opcode;
    logic [CH_W-1:0]         ch;
    logic signed [OFS_W-1:0] offset;
    logic [POS_W-1:0]        position;
  } edit_req_t;

  // --------------------------------------------------------------------------
  // Text model and result checker. The text sits outside [gap_lo, gap_hi),
  // the cursor is gap_lo; each accepted request queues the result it predicts.
  // --------------------------------------------------------------------------
  class text_scoreboard;
    logic [CH_W-1:0] chars [CAP];
    int unsigned     gap_lo;
    int unsigned     gap_hi;
    res_t            due_results [$];
    int unsigned     mismatches;

    function new();
      foreach (chars[i]) chars[i] = '0;
      gap_lo     = 0;
      gap_hi     = CAP;
      mismatches = 0;
    endfunction

    function int unsigned text_len();
      return CAP - (gap_hi - gap_lo);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Copy characters across the gap one at a time until the cursor lands.
    function void shift_gap(int unsigned target);
      while (gap_lo > target) begin
        gap_lo--;
        gap_hi--;
        chars[gap_hi] = chars[gap_lo];
      end
      while (gap_lo < target && gap_hi < CAP) begin
        chars[gap_lo] = chars[gap_hi];
        gap_lo++;
        gap_hi++;
      end
    endfunction

    function void note_request(edit_req_t r);
      res_t        exp;
      int unsigned len;
      int unsigned idx;
      int          target;

      len    = text_len();
      exp    = '0;
      exp.status = ST_OK;
      case (r.opcode)
        OP_INSERT: begin
          if (gap_lo >= gap_hi) begin
            exp.status = ST_FULL;
          end else begin
            chars[gap_lo] = r.ch;
            gap_lo++;
          end
        end
        OP_MOVE_REL: begin
          target = int'(gap_lo) + int'(r.offset);
          if (target < 0 || target > int'(len)) exp.status = ST_RANGE;
          else shift_gap(int'(target));
        end
        OP_MOVE_ABS: begin
          if (r.position > len) exp.status = ST_RANGE;
          else shift_gap(r.position);
        end
        OP_DEL_FWD: begin
          if (r.position > CAP - gap_hi) exp.status = ST_RANGE;
          else gap_hi += r.position;
        end
        OP_DEL_BWD: begin
          if (r.position > gap_lo) exp.status = ST_RANGE;
          else gap_lo -= r.position;
        end
        OP_READ: begin
          if (r.position >= len) begin
            exp.status = ST_RANGE;
          end else begin
            idx = (r.position < gap_lo) ? r.position : r.position + (gap_hi - gap_lo);
            if (idx < CAP) exp.rd_char = chars[idx];
          end
        end
        OP_CLEAR: begin
          gap_lo = 0;
          gap_hi = CAP;
        end
        default: exp.status = ST_RANGE;
      endcase
      exp.text_length = POS_W'(text_len());
      exp.cursor      = POS_W'(gap_lo);
      due_results.push_back(exp);
    endfunction

    task report(string what);
      mismatches++;
      // Hold the log to a readable size; keep counting beyond it.
      if (mismatches <= MAX_PRINTED) $display("MISMATCH #%0d: %s", mismatches, what);
    endtask

    task check_result(res_t got);
      res_t exp;
      if (due_results.size() == 0) begin
        report($sformatf("result with no request waiting: %p", got));
        return;
      end
      exp = due_results.pop_front();
      if (got.rd_char !== exp.rd_char)
        report($sformatf("rd_char got %0h expected %0h", got.rd_char, exp.rd_char));
      if (got.status !== exp.status)
        report($sformatf("status got %0d expected %0d", got.status, exp.status));
      if (got.text_length !== exp.text_length)
        report($sformatf("text_length got %0d expected %0d",
                         got.text_length, exp.text_length));
      if (got.cursor !== exp.cursor)
        report($sformatf("cursor got %0d expected %0d", got.cursor, exp.cursor));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic calm;            // suppress idling on both sides while high
  int unsigned cycle_count = 0;

  gbts_in_if  req_if ();
  gbts_out_if res_if ();

  gap_buffer_text_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  text_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up on a hung block; the limit sits far above the slowest good run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side stalls at random, about 15 percent of the time, except while calm.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // Sample both handshakes on the edge; values seen here are the pre-edge ones.
  always @(posedge clk_i) begin
    edit_req_t r;
    res_t      got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        r.opcode   = req_if.opcode;
        r.ch       = req_if.ch;
        r.offset   = req_if.offset;
        r.position = req_if.position;
        sb.note_request(r);
      end
      if (res_if.valid && res_if.ready) begin
        got.rd_char     = res_if.rd_char;
        got.status      = res_if.status;
        got.text_length = res_if.text_length;
        got.cursor      = res_if.cursor;
        sb.check_result(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Present one request and hold it until the block takes it. Random idle
  // cycles go in front unless calm; back-to-back requests keep valid high.
  task send_edit(input logic [OPC_W-1:0] op, input logic [CH_W-1:0] c,
                 input logic signed [OFS_W-1:0] ofs, input logic [POS_W-1:0] pos);
    if (!calm && $urandom_range(0, 99) < 15) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.ch       <= c;
    req_if.offset   <= ofs;
    req_if.position <= pos;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  // Let the current edge pass first so the request taken on it is already noted.
  task drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One random request, shaped by the current text so most of them land.
  task send_random_edit();
    int unsigned len;
    int unsigned cur;
    int unsigned pick;
    int          t;

    len  = sb.text_len();
    cur  = sb.gap_lo;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_edit(OP_INSERT, CH_W'($urandom), '0, '0);
    end else if (pick < 45) begin
      // Half short hops round the cursor, half to anywhere in the text or one past its end.
      if ($urandom_range(0, 1)) t = int'($urandom_range(0, 12)) - 6;
      else t = int'($urandom_range(0, len + 1)) - int'(cur);
      send_edit(OP_MOVE_REL, CH_W'($urandom), OFS_W'(t), POS_W'($urandom));
    end else if (pick < 55) begin
      send_edit(OP_MOVE_ABS, CH_W'($urandom), OFS_W'($urandom),
                POS_W'($urandom_range(0, len + 2)));
    end else if (pick < 63) begin
      send_edit(OP_DEL_FWD, CH_W'($urandom), OFS_W'($urandom),
                POS_W'($urandom_range(0, 6)));
    end else if (pick < 71) begin
      send_edit(OP_DEL_BWD, CH_W'($urandom), OFS_W'($urandom),
                POS_W'($urandom_range(0, 6)));
    end else if (pick < 87) begin
      send_edit(OP_READ, CH_W'($urandom), OFS_W'($urandom),
                POS_W'($urandom_range(0, len)));
    end else if (pick < 89) begin
      send_edit(OP_CLEAR, CH_W'($urandom), OFS_W'($urandom), POS_W'($urandom));
    end else begin
      // Noise: any opcode, every field bit free.
      send_edit(OPC_W'($urandom_range(0, 7)), CH_W'($urandom), OFS_W'($urandom),
                POS_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb           = new();
    calm         = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_INSERT;
    req_if.ch       <= '0;
    req_if.offset   <= '0;
    req_if.position <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: refusals on an empty text, then small edits at the extremes.
    send_edit(OP_READ,     '0, '0, '0);              // read past the end
    send_edit(OP_DEL_FWD,  '0, '0, '0);              // zero count is fine
    send_edit(OP_DEL_BWD,  '0, '0, 13'd1);           // nothing before cursor
    send_edit(OP_MOVE_REL, '0, -14'sd1, '0);         // target below zero
    send_edit(OP_MOVE_ABS, '0, '0, 13'd1);           // target past length
    send_edit(OP_UNUSED,   8'hFF, 14'h3FFF, 13'h1FFF);
    send_edit(OP_INSERT,   8'h00, '0, '0);
    send_edit(OP_INSERT,   8'hFF, '0, '0);
    send_edit(OP_INSERT,   8'h5A, '0, '0);
    send_edit(OP_INSERT,   8'hA5, '0, '0);
    send_edit(OP_MOVE_ABS, '0, '0, '0);
    send_edit(OP_MOVE_REL, '0, 14'sd4, '0);          // back to the end
    send_edit(OP_MOVE_REL, '0, 14'sd1, '0);          // one past the end
    send_edit(OP_MOVE_REL, '0, 14'h2000, '0);        // most negative offset
    send_edit(OP_MOVE_REL, '0, 14'h1FFF, '0);        // most positive offset
    send_edit(OP_MOVE_ABS, '0, '0, 13'h1FFF);
    send_edit(OP_READ,     '0, '0, 13'd0);
    send_edit(OP_READ,     '0, '0, 13'd3);
    send_edit(OP_READ,     '0, '0, 13'd4);           // index equal to length
    send_edit(OP_MOVE_ABS, '0, '0, 13'd2);
    send_edit(OP_DEL_FWD,  '0, '0, 13'd3);           // more than after cursor
    send_edit(OP_DEL_FWD,  '0, '0, 13'd1);
    send_edit(OP_DEL_BWD,  '0, '0, 13'd2);
    send_edit(OP_DEL_FWD,  '0, '0, 13'h1FFF);
    send_edit(OP_CLEAR,    '0, '0, '0);
    drain_results();

    // Build a long text; the first half runs with no idling on either side.
    calm = 1'b1;
    for (int unsigned i = 0; i < FILL_CHARS; i++) begin
      if (i == FILL_CHARS / 2) calm = 1'b0;
      send_edit(OP_INSERT, CH_W'($urandom), '0, '0);
    end
    // Long moves across the text, then empty it by deletes.
    send_edit(OP_MOVE_ABS, '0, '0, '0);
    send_edit(OP_INSERT,   8'h3C, '0, '0);           // at the front
    send_edit(OP_MOVE_REL, '0, OFS_W'(FILL_CHARS), '0);   // back to the end
    send_edit(OP_MOVE_REL, '0, OFS_W'(CAP), '0);     // far past the end
    send_edit(OP_READ,     '0, '0, '0);
    send_edit(OP_READ,     '0, '0, POS_W'(FILL_CHARS));   // last character
    send_edit(OP_MOVE_ABS, '0, '0, POS_W'(HALF_TEXT));
    send_edit(OP_READ,     '0, '0, POS_W'(HALF_TEXT));
    send_edit(OP_DEL_BWD,  '0, '0, POS_W'(HALF_TEXT + 1));
    send_edit(OP_DEL_BWD,  '0, '0, POS_W'(HALF_TEXT));
    send_edit(OP_DEL_FWD,  '0, '0, POS_W'(HALF_TEXT + 1));
    send_edit(OP_DEL_FWD,  '0, '0, POS_W'(HALF_TEXT));
    send_edit(OP_CLEAR,    '0, '0, '0);
    drain_results();

    // Random edit traffic, pausing now and then until the block is empty.
    for (int unsigned n = 0; n < RANDOM_EDITS; n++) begin
      if (n % 300 == 299) drain_results();
      send_random_edit();
    end

    // Wait out the last results, then let the bench settle for anything stray.
    drain_results();
    repeat (SETTLE) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
